[rtl/psrs_pkg.sv]
package psrs_pkg;

   // Number range covered by the primality map
   localparam int MAX_NUMBER = 16384;
   localparam int NUM_W      = $clog2(MAX_NUMBER);
   localparam int SQRT_W     = (NUM_W + 1) / 2 + 1;

   // Result widths
   localparam int SUM_W   = 24;
   localparam int TOTAL_W = 32;

   // Limit after reset
   localparam logic [NUM_W-1:0] LIMIT_RESET = NUM_W'(10000);

   typedef struct packed {
      logic [NUM_W-1:0] range_first;
      logic [NUM_W-1:0] range_last;
   } req_type;

   typedef struct packed {
      logic [SUM_W-1:0]   interval_sum;
      logic [TOTAL_W-1:0] running_total;
   } rsp_type;

endpackage

[rtl/psrs_ram.sv]
module psrs_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 16384
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/prime_sieve_range_sum.sv]
// Sums the primes in an inclusive interval [range_first, range_last] using a
// one-bit-per-number primality map held in a single-port-write, registered-read
// RAM. The first query after reset or after a csr write first builds the map:
// a fill pass that marks each number from 0 to the limit (2 and up as prime),
// then the sieve, which reads each candidate n with n*n <= limit and, if it is
// still marked, clears its multiples from n*n up to the limit. Every query then
// scans its interval one number per cycle through the RAM read port; an empty
// interval skips the scan. One query is worked at a time; a finished result
// waits in the output register while the next query is taken. Numbers above
// the limit count as not prime; running_total saturates.
module prime_sieve_range_sum
   import psrs_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [NUM_W-1:0] csr_data
);

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_FILL     = 3'd1;
   localparam logic [2:0] ST_SV_RD    = 3'd2;
   localparam logic [2:0] ST_SV_WAIT  = 3'd3;
   localparam logic [2:0] ST_SV_CLR   = 3'd4;
   localparam logic [2:0] ST_SCAN_BEG = 3'd5;
   localparam logic [2:0] ST_SCAN     = 3'd6;
   localparam logic [2:0] ST_FINISH   = 3'd7;

   logic [2:0]         state_ff, state_in;
   logic [NUM_W-1:0]   limit_ff, limit_in;
   logic               map_ready_ff, map_ready_in;
   logic [NUM_W-1:0]   n_ff, n_in;
   logic [NUM_W:0]     m_ff, m_in;
   logic [NUM_W-1:0]   first_ff, first_in;
   logic [NUM_W-1:0]   last_ff, last_in;
   logic               pipe_vld_ff, pipe_vld_in;
   logic [NUM_W-1:0]   pipe_num_ff, pipe_num_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic               ram_wr_en;
   logic [NUM_W-1:0]   ram_wr_addr;
   logic               ram_wr_data;
   logic [NUM_W-1:0]   ram_rd_addr;
   logic               ram_rd_data;

   logic [2*SQRT_W-1:0] n_sq;
   logic [NUM_W:0]      m_next;
   logic [SUM_W:0]      sum_add;
   logic [TOTAL_W:0]    total_add;
   logic                out_free;

   psrs_ram #(
      .WIDTH (1),
      .DEPTH (MAX_NUMBER)
   ) u_map (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign n_sq      = n_ff[SQRT_W-1:0] * n_ff[SQRT_W-1:0];
   assign m_next    = m_ff + {1'b0, n_ff};
   assign sum_add   = {1'b0, sum_ff} + {{SUM_W{1'b0}}, 1'b0} + (SUM_W+1)'(pipe_num_ff);
   assign total_add = {1'b0, total_ff} + (TOTAL_W+1)'(sum_ff);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // RAM port control
   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = n_ff;
      ram_wr_data = (n_ff >= NUM_W'(2));
      ram_rd_addr = n_ff;
      case (state_ff)
         ST_FILL: begin
            ram_wr_en = 1'b1;
         end
         ST_SV_CLR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = m_ff[NUM_W-1:0];
            ram_wr_data = 1'b0;
         end
         default: begin
            ram_wr_en = 1'b0;
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      limit_in     = limit_ff;
      map_ready_in = map_ready_ff;
      n_in         = n_ff;
      m_in         = m_ff;
      first_in     = first_ff;
      last_in      = last_ff;
      pipe_vld_in  = 1'b0;
      pipe_num_in  = n_ff;
      sum_in       = sum_ff;
      total_in     = total_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;

      // csr write invalidates the map
      if (csr_valid) begin
         limit_in     = csr_data;
         map_ready_in = 1'b0;
      end

      // accumulate scanned primes in the cycle after the read
      if (pipe_vld_ff && ram_rd_data) begin
         sum_in = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               first_in = req_data.range_first;
               last_in  = (req_data.range_last > limit_ff) ? limit_ff
                                                           : req_data.range_last;
               n_in     = '0;
               state_in = map_ready_ff ? ST_SCAN_BEG : ST_FILL;
            end
         end
         ST_FILL: begin
            if (n_ff == limit_ff) begin
               n_in     = NUM_W'(2);
               state_in = ST_SV_RD;
            end else begin
               n_in = n_ff + NUM_W'(1);
            end
         end
         ST_SV_RD: begin
            if (n_sq > (2*SQRT_W)'(limit_ff)) begin
               map_ready_in = 1'b1;
               state_in     = ST_SCAN_BEG;
            end else begin
               state_in = ST_SV_WAIT;
            end
         end
         ST_SV_WAIT: begin
            if (ram_rd_data) begin
               m_in     = (NUM_W+1)'(n_sq);
               state_in = ST_SV_CLR;
            end else begin
               n_in     = n_ff + NUM_W'(1);
               state_in = ST_SV_RD;
            end
         end
         ST_SV_CLR: begin
            m_in = m_next;
            if (m_next > (NUM_W+1)'(limit_ff)) begin
               n_in     = n_ff + NUM_W'(1);
               state_in = ST_SV_RD;
            end
         end
         ST_SCAN_BEG: begin
            sum_in = '0;
            n_in   = first_ff;
            state_in = (first_ff > last_ff) ? ST_FINISH : ST_SCAN;
         end
         ST_SCAN: begin
            pipe_vld_in = 1'b1;
            pipe_num_in = n_ff;
            if (n_ff == last_ff) begin
               state_in = ST_FINISH;
            end else begin
               n_in = n_ff + NUM_W'(1);
            end
         end
         ST_FINISH: begin
            // last scanned number lands in the sum this cycle; respond once it has landed
            if (!pipe_vld_ff && out_free) begin
               total_in = total_add[TOTAL_W] ? {TOTAL_W{1'b1}}
                                             : total_add[TOTAL_W-1:0];
               rsp_valid_in              = 1'b1;
               rsp_data_in.interval_sum  = sum_ff;
               rsp_data_in.running_total = total_in;
               state_in                  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         limit_ff     <= LIMIT_RESET;
         map_ready_ff <= 1'b0;
         total_ff     <= '0;
         pipe_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         limit_ff     <= limit_in;
         map_ready_ff <= map_ready_in;
         total_ff     <= total_in;
         pipe_vld_ff  <= pipe_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      m_ff        <= m_in;
      first_ff    <= first_in;
      last_ff     <= last_in;
      pipe_num_ff <= pipe_num_in;
      sum_ff      <= sum_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

[test/prime_sieve_range_sum_test.sv]
module prime_sieve_range_sum_test;
   import psrs_pkg::*;

   // One row of the directed probe table
   typedef struct {
      int unsigned first;
      int unsigned last;
      bit          known;   // interval_sum typed in below
      int unsigned sum;
   } probe_row_type;

   localparam int NUM_PROBES      = 18;
   localparam int NUM_PHASES      = 6;
   localparam int ITEMS_PER_PHASE = 16;
   localparam int HOLD_CYCLES     = 400;
   localparam int HOLD_AFTER      = 20;
   localparam int DRAIN_CYCLES    = 32;

   localparam logic [SUM_W-1:0]   SUM_SAT   = '1;
   localparam logic [TOTAL_W-1:0] TOTAL_SAT = '1;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   req_type          req_data  = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   rsp_type          rsp_data;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [NUM_W-1:0] csr_data  = '0;

   // Predictor state: own sieve, limit and running total
   bit                 prime_flags [MAX_NUMBER];
   bit                 sieve_built = 1'b0;
   logic [NUM_W-1:0]   sieve_limit = LIMIT_RESET;
   logic [TOTAL_W-1:0] total_acc   = '0;

   rsp_type expected_sums [$];
   int      mismatch_count = 0;
   int      results_seen   = 0;
   int      queries_sent   = 0;
   bit      calm           = 1'b0;

   // Directed probes, all at the limit after reset
   probe_row_type probe_table [NUM_PROBES] = '{
      '{5,     3,     1'b1, 0},      // first above last: empty
      '{0,     1,     1'b1, 0},
      '{2,     2,     1'b1, 2},
      '{0,     10,    1'b1, 17},
      '{1,     100,   1'b1, 1060},
      '{97,    97,    1'b1, 97},
      '{4,     4,     1'b1, 0},
      '{9973,  10000, 1'b1, 9973},   // largest prime under the limit
      '{10000, 10005, 1'b1, 0},      // just past the limit counts as composite
      '{10001, 16383, 1'b1, 0},      // wholly above the limit
      '{16383, 16383, 1'b1, 0},
      '{16383, 0,     1'b1, 0},      // widest empty interval
      '{0,     0,     1'b1, 0},
      '{0,     16383, 1'b0, 0},      // full scan
      '{8190,  8290,  1'b0, 0},
      '{4096,  2048,  1'b1, 0},
      '{1000,  1100,  1'b0, 0},
      '{9000,  9999,  1'b0, 0}
   };

   prime_sieve_range_sum u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Largest number the sieve examines
   function automatic int sieve_top();
      return (int'(sieve_limit) > MAX_NUMBER - 1) ? MAX_NUMBER - 1 : int'(sieve_limit);
   endfunction

   // Plain Eratosthenes over 0..sieve_top()
   function automatic void build_sieve();
      int lim;
      lim = sieve_top();
      foreach (prime_flags[n]) prime_flags[n] = (n >= 2 && n <= lim);
      for (int n = 2; n * n <= lim; n++) begin
         if (prime_flags[n]) begin
            for (int m = n * n; m <= lim; m += n) prime_flags[m] = 1'b0;
         end
      end
      sieve_built = 1'b1;
   endfunction

   // Sum of primes in the interval plus the saturating running total
   function automatic rsp_type predict_query(req_type q);
      rsp_type         r;
      int              hi;
      longint unsigned acc;
      longint unsigned tot;
      if (!sieve_built) build_sieve();
      hi = (int'(q.range_last) > sieve_top()) ? sieve_top() : int'(q.range_last);
      acc = 0;
      for (int n = int'(q.range_first); n <= hi; n++) begin
         if (prime_flags[n]) acc += n;
      end
      if (acc > SUM_SAT) acc = SUM_SAT;
      tot = total_acc + acc;
      if (tot > TOTAL_SAT) tot = TOTAL_SAT;
      total_acc = tot[TOTAL_W-1:0];
      r.interval_sum  = acc[SUM_W-1:0];
      r.running_total = total_acc;
      return r;
   endfunction

   // Mostly short intervals near or under the limit; some wide or empty ones
   function automatic req_type random_query();
      req_type q;
      int      top;
      int      stop;
      int      pick;
      top = (sieve_top() + 16 > MAX_NUMBER - 1) ? MAX_NUMBER - 1 : sieve_top() + 16;
      if ($urandom_range(0, 1) == 0) q.range_first = NUM_W'($urandom_range(0, top));
      else q.range_first = NUM_W'($urandom);
      pick = $urandom_range(0, 11);
      if (pick == 0) begin
         q.range_last = NUM_W'($urandom);
      end else if (pick == 1 && q.range_first != 0) begin
         q.range_last = NUM_W'($urandom_range(0, q.range_first - 1));
      end else begin
         stop = int'(q.range_first) + $urandom_range(0, 63);
         q.range_last = NUM_W'((stop > MAX_NUMBER - 1) ? MAX_NUMBER - 1 : stop);
      end
      return q;
   endfunction

   // Offer one query and queue its expected result on transfer
   task automatic offer_query(req_type q, bit known = 1'b0, int unsigned known_sum = 0);
      rsp_type r;
      req_valid <= 1'b1;
      req_data  <= q;
      do @(posedge clock); while (!req_ready);
      r = predict_query(q);
      if (known) r.interval_sum = known_sum[SUM_W-1:0];
      expected_sums.push_back(r);
      queries_sent++;
   endtask

   // Random sender idle burst, skipped in quiet stretches
   task automatic sender_gap();
      if (!calm && (queries_sent % 40) < 28 && $urandom_range(0, 2) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_sums.size() != 0) @(posedge clock);
   endtask

   // Limit write only with the block idle; next query rebuilds the map
   task automatic write_limit(logic [NUM_W-1:0] value);
      wait_drained();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sieve_limit = value;
      sieve_built = 1'b0;
   endtask

   // Stimulus
   initial begin
      req_type          q;
      logic [NUM_W-1:0] phase_limits [NUM_PHASES];
      phase_limits[0] = NUM_W'(MAX_NUMBER - 1);
      phase_limits[1] = NUM_W'(2);
      phase_limits[2] = NUM_W'(0);
      phase_limits[3] = NUM_W'(1);
      phase_limits[4] = NUM_W'($urandom_range(3, MAX_NUMBER - 2));
      phase_limits[5] = NUM_W'($urandom_range(3, 400));

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (probe_table[i]) begin
         q.range_first = NUM_W'(probe_table[i].first);
         q.range_last  = NUM_W'(probe_table[i].last);
         offer_query(q, probe_table[i].known, probe_table[i].sum);
         sender_gap();
      end

      // Random phases, each at its own limit; the last one runs without idling
      for (int p = 0; p < NUM_PHASES; p++) begin
         write_limit(phase_limits[p]);
         calm = (p == NUM_PHASES - 1);
         for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
            if (p == 0 && k == ITEMS_PER_PHASE / 2) wait_drained();
            offer_query(random_query());
            sender_gap();
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("[prime_sieve_range_sum] OK");
      end else begin
         $display("[prime_sieve_range_sum] ERROR");
      end
      $finish;
   end

   // Result side: check each transfer, then pick next cycle's ready
   initial begin
      int      stall_left;
      int      hold_left;
      bit      held;
      rsp_type want;
      stall_left = 0;
      hold_left  = 0;
      held       = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            if (expected_sums.size() == 0) begin
               $error("unexpected result: interval_sum %0d running_total %0d",
                      rsp_data.interval_sum, rsp_data.running_total);
               mismatch_count++;
            end else begin
               want = expected_sums.pop_front();
               if (rsp_data.interval_sum !== want.interval_sum) begin
                  $error("interval_sum: expected %0d, actual %0d",
                         want.interval_sum, rsp_data.interval_sum);
                  mismatch_count++;
               end
               if (rsp_data.running_total !== want.running_total) begin
                  $error("running_total: expected %0d, actual %0d",
                         want.running_total, rsp_data.running_total);
                  mismatch_count++;
               end
            end
            results_seen++;
         end

         // one long hold-off so the block backs up into its input
         if (!held && results_seen == HOLD_AFTER) begin
            held      = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (!calm && (results_seen % 30) < 20 && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(1, 7) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Watchdog
   initial begin
      #500_000_000;
      $display("[prime_sieve_range_sum] ERROR");
      $finish;
   end

endmodule

[sim.f]
rtl/psrs_pkg.sv
rtl/psrs_ram.sv
rtl/prime_sieve_range_sum.sv
test/prime_sieve_range_sum_test.sv
